// ===== hw/rtl/lpmd_pkg.sv =====
// shared types and constants for the length-prefixed message deframer
`timescale 1ns / 1ps
package lpmd_pkg;

	localparam int unsigned LEN_BYTES = 4;           // length field bytes, counted in the length
	localparam int unsigned LEN_W = 32;              // length field width
	localparam int unsigned CNT_W = $clog2(LEN_BYTES) + 1;

	typedef enum logic [1:0] {
		ROLE_TYPE    = 2'd0,
		ROLE_LENGTH  = 2'd1,
		ROLE_PAYLOAD = 2'd2
	} byte_role_t;

	typedef struct packed {
		logic             malformed;
		logic             frame_end;
		logic [LEN_W-1:0] payload_length;
		logic [7:0]       frame_type;
		byte_role_t       byte_role;
		logic [7:0]       data_byte;
	} result_t;

endpackage

// ===== hw/rtl/lpmd_parser.sv =====
// frame parser: header state and per-byte labeling
`timescale 1ns / 1ps
module lpmd_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic [7:0]        in_byte,
	input  logic              startup_frame,
	output lpmd_pkg::result_t result
);
	import lpmd_pkg::*;

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_HEADER  = 2'd1,
		PH_PAYLOAD = 2'd2
	} phase_t;

	localparam logic [LEN_W-1:0] LEN_MIN = LEN_W'(LEN_BYTES);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(LEN_BYTES);

	phase_t             phase_q, phase_d;
	logic [CNT_W-2:0]   hc_q, hc_d;
	logic [7:0]         type_q, type_d;
	logic [LEN_W-1:0]   ls_q, ls_d;
	logic [LEN_W-1:0]   rem_q, rem_d;

	// length-byte path, shared by header bytes and the first byte of a startup frame
	logic               in_header;
	logic [CNT_W-2:0]   hc_base;
	logic [LEN_W-1:0]   ls_base;
	logic [LEN_W-1:0]   ls_new;
	logic [CNT_W-1:0]   cnt_new;
	logic [LEN_W-1:0]   ls_new_pay;
	logic [LEN_W-1:0]   ls_q_pay;
	logic [LEN_W-1:0]   rem_dec;

	assign in_header  = (phase_q == PH_HEADER);
	assign hc_base    = in_header ? hc_q : '0;
	assign ls_base    = in_header ? ls_q : '0;
	assign ls_new     = {ls_base[LEN_W-9:0], in_byte};
	assign cnt_new    = {1'b0, hc_base} + CNT_W'(1);
	assign ls_new_pay = ls_new - LEN_MIN;
	assign ls_q_pay   = ls_q - LEN_MIN;
	assign rem_dec    = (rem_q != '0) ? rem_q - LEN_W'(1) : rem_q;

	always_comb begin
		phase_d = phase_q;
		hc_d    = hc_q;
		type_d  = type_q;
		ls_d    = ls_q;
		rem_d   = rem_q;

		result.data_byte      = in_byte;
		result.byte_role      = ROLE_TYPE;
		result.frame_type     = '0;
		result.payload_length = '0;
		result.frame_end      = 1'b0;
		result.malformed      = 1'b0;

		unique case (phase_q)
			PH_PAYLOAD: begin
				result.byte_role      = ROLE_PAYLOAD;
				result.frame_type     = type_q;
				result.payload_length = ls_q_pay;
				rem_d = rem_dec;
				if (rem_dec == '0) begin
					result.frame_end = 1'b1;
					phase_d = PH_IDLE;
				end
			end
			default: begin
				// idle (and the unused code) or header
				if (!in_header && !startup_frame) begin
					type_d  = in_byte;
					hc_d    = '0;
					ls_d    = '0;
					rem_d   = '0;
					result.byte_role  = ROLE_TYPE;
					result.frame_type = in_byte;
					phase_d = PH_HEADER;
				end else begin
					if (!in_header) begin
						type_d = '0;
					end
					result.byte_role  = ROLE_LENGTH;
					result.frame_type = in_header ? type_q : 8'd0;
					ls_d  = ls_new;
					hc_d  = cnt_new[CNT_W-2:0];
					rem_d = in_header ? rem_q : '0;
					if (cnt_new != CNT_LAST) begin
						phase_d = PH_HEADER;
					end else begin
						hc_d = '0;
						if (ls_new < LEN_MIN) begin
							// short length field: frame ends on its last header byte
							result.frame_end = 1'b1;
							result.malformed = 1'b1;
							rem_d   = '0;
							phase_d = PH_IDLE;
						end else begin
							rem_d = ls_new_pay;
							result.payload_length = ls_new_pay;
							if (ls_new_pay == '0) begin
								result.frame_end = 1'b1;
								phase_d = PH_IDLE;
							end else begin
								phase_d = PH_PAYLOAD;
							end
						end
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			hc_q    <= '0;
			type_q  <= '0;
			ls_q    <= '0;
			rem_q   <= '0;
		end else if (take) begin
			phase_q <= phase_d;
			hc_q    <= hc_d;
			type_q  <= type_d;
			ls_q    <= ls_d;
			rem_q   <= rem_d;
		end
	end

endmodule

// ===== hw/rtl/lpmd_out_reg.sv =====
// result register with stream handshake toward the consumer
`timescale 1ns / 1ps
module lpmd_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  lpmd_pkg::result_t result,
	output logic              space,
	input  logic              out_ready,
	output logic              out_valid,
	output lpmd_pkg::result_t out_result
);
	import lpmd_pkg::*;

	logic    valid_q;
	result_t data_q;

	assign space      = !valid_q || out_ready;
	assign out_valid  = valid_q;
	assign out_result = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (space) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= result;
		end
	end

endmodule

// ===== hw/rtl/length_prefixed_message_deframer_unit.sv =====
// top level of the length-prefixed message deframer
`timescale 1ns / 1ps
// Splits a byte stream into length-prefixed messages, one byte per item. A normal
// frame is a type byte, a 4-byte big-endian length that counts its own four bytes,
// then length-4 payload bytes; a startup frame (s_tuser high on its first byte)
// has no type byte and reports type 0. Every input item yields exactly one output
// item labeling the byte's role with the frame type and payload length; m_tlast
// marks the last byte of a frame, and a length below 4 ends the frame after its
// header with the malformed flag set. Throughput is one item per clock while the
// consumer keeps up: the parser state updates in the cycle a byte is taken and
// the result lands in a single output register, valid from the next cycle on.
// s_tready stays high while the output register is empty or being drained, so a
// stalled consumer stalls input only once its one waiting result is still unclaimed.
module length_prefixed_message_deframer_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // in_byte
	input  logic [0:0]  s_tuser,   // startup_frame
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // data_byte [7:0], frame_type [15:8], payload_length [47:16]
	output logic [2:0]  m_tuser,   // byte_role [1:0], malformed [2]
	output logic        m_tlast    // frame_end
);
	import lpmd_pkg::*;

	logic    take;
	logic    space;
	result_t result;
	result_t out_result;

	// an item is taken whenever the result register has room for it
	assign s_tready = space;
	assign take     = s_tvalid && space;

	lpmd_parser u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (take),
		.in_byte      (s_tdata),
		.startup_frame(s_tuser[0]),
		.result       (result)
	);

	lpmd_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (take),
		.result    (result),
		.space     (space),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_result(out_result)
	);

	// pack the result fields onto the stream bus
	assign m_tdata = {out_result.payload_length, out_result.frame_type, out_result.data_byte};
	assign m_tuser = {out_result.malformed, out_result.byte_role};
	assign m_tlast = out_result.frame_end;

endmodule

// ===== verif/deframe_checker.sv =====
// output stream monitor and byte-labeling predictor for the message deframer
`timescale 1ns / 1ps
module deframe_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic [0:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [47:0] m_tdata,
	input  logic [2:0]  m_tuser,
	input  logic        m_tlast,
	output int          fail_count,
	output int          pending_count
);
	import lpmd_pkg::*;

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_HEADER  = 2'd1,
		PH_PAYLOAD = 2'd2
	} parse_phase_t;

	parse_phase_t parse_phase = PH_IDLE;
	logic [2:0]   len_seen    = '0;
	logic [7:0]   cur_type    = '0;
	logic [31:0]  len_acc     = '0;
	logic [31:0]  bytes_left  = '0;
	result_t      label_queue[$];
	int           errors      = 0;

	// one length byte, big-endian; the fourth one closes the header
	function automatic void take_length(input logic [7:0] b, inout result_t r);
		logic [2:0] n;
		n = len_seen + 3'd1;
		len_acc = {len_acc[23:0], b};
		len_seen = n;
		r.byte_role = ROLE_LENGTH;
		r.frame_type = cur_type;
		if (n < LEN_BYTES) begin
			parse_phase = PH_HEADER;
		end else begin
			len_seen = '0;
			if (len_acc < LEN_BYTES) begin
				// length too short to count itself
				r.frame_end = 1'b1;
				r.malformed = 1'b1;
				bytes_left = '0;
				parse_phase = PH_IDLE;
			end else begin
				bytes_left = len_acc - LEN_BYTES;
				r.payload_length = bytes_left;
				if (bytes_left == 0) begin
					r.frame_end = 1'b1;
					parse_phase = PH_IDLE;
				end else begin
					parse_phase = PH_PAYLOAD;
				end
			end
		end
	endfunction

	function automatic result_t label_byte(input logic [7:0] b, input logic startup);
		result_t r;
		r = '0;
		r.data_byte = b;
		r.byte_role = ROLE_TYPE;
		case (parse_phase)
			PH_HEADER: take_length(b, r);
			PH_PAYLOAD: begin
				r.byte_role = ROLE_PAYLOAD;
				r.frame_type = cur_type;
				r.payload_length = len_acc - LEN_BYTES;
				if (bytes_left != 0)
					bytes_left = bytes_left - 1;
				if (bytes_left == 0) begin
					r.frame_end = 1'b1;
					parse_phase = PH_IDLE;
				end
			end
			default: begin
				len_seen = '0;
				len_acc = '0;
				bytes_left = '0;
				if (startup) begin
					cur_type = '0;
					take_length(b, r);
				end else begin
					cur_type = b;
					r.frame_type = b;
					parse_phase = PH_HEADER;
				end
			end
		endcase
		return r;
	endfunction

	// compare before predicting: a result never leaves in the cycle its byte enters
	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.data_byte = m_tdata[7:0];
				got.frame_type = m_tdata[15:8];
				got.payload_length = m_tdata[47:16];
				got.byte_role = byte_role_t'(m_tuser[1:0]);
				got.malformed = m_tuser[2];
				got.frame_end = m_tlast;
				if (label_queue.size() == 0) begin
					$error("output item with none expected: data_byte %0h", got.data_byte);
					errors++;
				end else begin
					want = label_queue.pop_front();
					if (got.data_byte !== want.data_byte) begin
						$error("data_byte: expected %0h, got %0h", want.data_byte, got.data_byte);
						errors++;
					end
					if (got.byte_role !== want.byte_role) begin
						$error("byte_role: expected %0d, got %0d", want.byte_role, got.byte_role);
						errors++;
					end
					if (got.frame_type !== want.frame_type) begin
						$error("frame_type: expected %0h, got %0h",
							want.frame_type, got.frame_type);
						errors++;
					end
					if (got.payload_length !== want.payload_length) begin
						$error("payload_length: expected %0h, got %0h",
							want.payload_length, got.payload_length);
						errors++;
					end
					if (got.frame_end !== want.frame_end) begin
						$error("frame_end: expected %0b, got %0b", want.frame_end, got.frame_end);
						errors++;
					end
					if (got.malformed !== want.malformed) begin
						$error("malformed: expected %0b, got %0b", want.malformed, got.malformed);
						errors++;
					end
				end
			end
			if (s_tvalid && s_tready)
				label_queue.push_back(label_byte(s_tdata, s_tuser[0]));
		end
		fail_count <= errors;
		pending_count <= label_queue.size();
	end

endmodule

// ===== verif/tb_top.sv =====
// stimulus, reset and verdict for the message deframer testbench
`timescale 1ns / 1ps
module tb_top;

	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_ITEMS = 440;

	// directed bytes, {startup flag, byte}
	localparam logic [8:0] DIRECTED [25] = '{
		// normal frame, type ff, length exactly four: ends on last length byte
		9'h0ff, 9'h000, 9'h000, 9'h000, 9'h004,
		// startup frame with length zero: malformed
		9'h100, 9'h000, 9'h000, 9'h000,
		// normal frame, type 00, length three: malformed
		9'h000, 9'h000, 9'h000, 9'h000, 9'h003,
		// startup frame, length five, startup flag held high mid-frame (ignored)
		9'h100, 9'h100, 9'h100, 9'h105, 9'h1ff,
		// normal frame, type 51, one payload byte
		9'h051, 9'h000, 9'h000, 9'h000, 9'h005, 9'h000
	};

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic [0:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        m_tlast;

	int fail_count;
	int pending_count;
	int cycle_count    = 0;
	int items_sent     = 0;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_request   = 0;
	int hold_left      = 0;

	length_prefixed_message_deframer_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	deframe_checker u_label_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tuser       (m_tuser),
		.m_tlast       (m_tlast),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// watchdog on the whole run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	// receiver: random back-pressure, or a long hold-off when one is requested
	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// offer one item, with random gaps before it, and wait for it to be taken;
	// valid stays high from one item to the next when no gap is drawn
	task automatic send_item(input logic [7:0] b, input logic startup);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tuser <= startup;
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	// one frame with random type and payload; noisy frames toggle the startup
	// flag on bytes after the first, where it must be ignored
	task automatic send_frame(input logic startup, input logic [7:0] ftype,
		input logic [31:0] flen, input int payload_bytes, input logic noisy);
		int i;
		if (!startup)
			send_item(ftype, 1'b0);
		for (i = 0; i < 4; i++) begin
			if (startup && i == 0)
				send_item(flen[31 -: 8], 1'b1);
			else
				send_item(flen[31 - 8 * i -: 8], noisy & 1'($urandom_range(1)));
		end
		for (i = 0; i < payload_bytes; i++)
			send_item(8'($urandom_range(255)), noisy & 1'($urandom_range(1)));
	endtask

	initial begin
		int phase_idx;
		int phase_start;
		int pick;
		logic [31:0] flen;

		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed: header extremes, short and exact lengths, startup frames
		for (int k = 0; k < 25; k++)
			send_item(DIRECTED[k][7:0], DIRECTED[k][8]);

		// random frames over four traffic phases
		for (phase_idx = 0; phase_idx < 4; phase_idx++) begin
			case (phase_idx)
				0: begin
					// full rate both ways, but first a long receiver hold-off
					// so the output register fills and input stalls
					send_idle_pct = 0;
					recv_stall_pct = 0;
					hold_request = 64;
				end
				1: begin
					send_idle_pct = 53;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 53;
				end
				default: begin
					send_idle_pct = 17;
					recv_stall_pct = 17;
				end
			endcase
			phase_start = items_sent;
			while (items_sent - phase_start < PHASE_ITEMS) begin
				pick = $urandom_range(99);
				if (pick < 8)
					flen = $urandom_range(3);            // malformed
				else if (pick < 14)
					flen = 4;                            // empty payload
				else if (pick < 96)
					flen = 4 + $urandom_range(1, 12);
				else
					flen = 4 + $urandom_range(13, 300);
				send_frame($urandom_range(99) < 25, 8'($urandom_range(255)), flen,
					(flen < 4) ? 0 : int'(flen - 4), $urandom_range(99) < 15);
			end
		end

		// largest length last: only the start of its payload is ever sent
		send_frame(1'($urandom_range(1)), 8'($urandom_range(255)), 32'hffff_ffff, 8, 1'b0);

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/lpmd_pkg.sv
hw/rtl/lpmd_parser.sv
hw/rtl/lpmd_out_reg.sv
hw/rtl/length_prefixed_message_deframer_unit.sv
verif/deframe_checker.sv
verif/tb_top.sv
